// ----- rtl/core/dinit_pkg.sv -----
// Shared types for the display init sequence parser.
// Holds result kind codes and the queue word between front and back stages.
// No dependencies.
package dinit_pkg;

    typedef enum logic [1:0] {
        KIND_CMD   = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_DELAY = 2'd2
    } kind_t;

    localparam logic [7:0] DELAY_LONG_IN = 8'd255;
    localparam logic [8:0] DELAY_LONG_MS = 9'd500;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = 1;

    // One classified result as it travels through the queue.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       frame_end;
        logic       list_end;
    } word_t;

endpackage

// ----- rtl/core/dinit_front.sv -----
// Front stage: accepts list bytes and tracks list / command / argument position.
// Pushes one classified word per result into the queue. Depends on dinit_pkg.
module dinit_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    output logic               in_ready,
    input  logic               q_full,
    output logic               q_push,
    output dinit_pkg::word_t   q_word
);

    typedef enum logic [4:0] {
        PH_COUNT = 5'b00001,
        PH_CMD   = 5'b00010,
        PH_NARGS = 5'b00100,
        PH_ARGS  = 5'b01000,
        PH_DELAY = 5'b10000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] commands_left_reg, commands_left_next;
    logic [6:0] args_left_reg, args_left_next;
    logic       delay_pending_reg, delay_pending_next;
    logic [7:0] held_command_reg, held_command_next;

    logic       accept;
    logic       emit;
    logic       last_cmd;
    logic [7:0] commands_dec;
    logic [6:0] args_dec;
    phase_t     finish_phase;

    assign in_ready     = !q_full;
    assign accept       = in_valid && in_ready;
    assign last_cmd     = (commands_left_reg == 8'd1);
    assign commands_dec = commands_left_reg - 8'd1;
    assign args_dec     = args_left_reg - 7'd1;
    assign finish_phase = last_cmd ? PH_COUNT : PH_CMD;

    always_comb begin
        phase_next         = phase_reg;
        commands_left_next = commands_left_reg;
        args_left_next     = args_left_reg;
        delay_pending_next = delay_pending_reg;
        held_command_next  = held_command_reg;
        emit               = 1'b0;
        q_word.kind        = dinit_pkg::KIND_CMD;
        q_word.data        = in_byte;
        q_word.frame_end   = 1'b0;
        q_word.list_end    = 1'b0;
        unique case (phase_reg)
            PH_CMD: begin
                held_command_next = in_byte;
                phase_next        = PH_NARGS;
            end
            PH_NARGS: begin
                emit               = 1'b1;
                q_word.data        = held_command_reg;
                delay_pending_next = in_byte[7];
                args_left_next     = in_byte[6:0];
                if (in_byte[6:0] != 7'd0) begin
                    phase_next = PH_ARGS;
                end else if (in_byte[7]) begin
                    q_word.frame_end = 1'b1;
                    phase_next       = PH_DELAY;
                end else begin
                    q_word.frame_end   = 1'b1;
                    q_word.list_end    = last_cmd;
                    commands_left_next = commands_dec;
                    phase_next         = finish_phase;
                end
            end
            PH_ARGS: begin
                emit           = 1'b1;
                q_word.kind    = dinit_pkg::KIND_DATA;
                args_left_next = args_dec;
                if (args_dec != 7'd0) begin
                    q_word.frame_end = 1'b0;
                end else if (delay_pending_reg) begin
                    q_word.frame_end = 1'b1;
                    phase_next       = PH_DELAY;
                end else begin
                    q_word.frame_end   = 1'b1;
                    q_word.list_end    = last_cmd;
                    commands_left_next = commands_dec;
                    phase_next         = finish_phase;
                end
            end
            PH_DELAY: begin
                emit               = 1'b1;
                q_word.kind        = dinit_pkg::KIND_DELAY;
                q_word.list_end    = last_cmd;
                delay_pending_next = 1'b0;
                commands_left_next = commands_dec;
                phase_next         = finish_phase;
            end
            default: begin
                // list count; a zero count stays here and emits nothing
                if (in_byte != 8'd0) begin
                    commands_left_next = in_byte;
                    phase_next         = PH_CMD;
                end else begin
                    phase_next = PH_COUNT;
                end
            end
        endcase
    end

    assign q_push = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_COUNT;
            commands_left_reg <= 8'd0;
            args_left_reg     <= 7'd0;
            delay_pending_reg <= 1'b0;
            held_command_reg  <= 8'd0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            commands_left_reg <= commands_left_next;
            args_left_reg     <= args_left_next;
            delay_pending_reg <= delay_pending_next;
            held_command_reg  <= held_command_next;
        end
    end

endmodule

// ----- rtl/core/dinit_queue.sv -----
// Two-entry word queue that decouples the front and back stages.
// Depends on dinit_pkg.
module dinit_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  dinit_pkg::word_t   push_word,
    output logic               full,
    input  logic               pop,
    output logic               avail,
    output dinit_pkg::word_t   head_word
);

    localparam int unsigned AW = dinit_pkg::QUEUE_AW;

    dinit_pkg::word_t            mem_reg [dinit_pkg::QUEUE_DEPTH];
    logic [AW-1:0]               wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]                 count_reg, count_next;

    assign full      = (count_reg == (AW+1)'(dinit_pkg::QUEUE_DEPTH));
    assign avail     = (count_reg != '0);
    assign head_word = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/core/dinit_back.sv -----
// Back stage: drains queued words into the result register and maps delays.
// Depends on dinit_pkg.
module dinit_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_avail,
    input  dinit_pkg::word_t   q_word,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_kind,
    output logic [8:0]         out_value,
    output logic               out_frame_end,
    output logic               out_list_end
);

    logic       valid_reg;
    logic [1:0] kind_reg;
    logic [8:0] value_reg, value_next;
    logic       frame_end_reg;
    logic       list_end_reg;

    // refill whenever the result register is empty or being taken
    assign q_pop = q_avail && (!valid_reg || out_ready);

    always_comb begin
        value_next = {1'b0, q_word.data};
        if (q_word.kind == dinit_pkg::KIND_DELAY && q_word.data == dinit_pkg::DELAY_LONG_IN) begin
            value_next = dinit_pkg::DELAY_LONG_MS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg      <= q_word.kind;
            value_reg     <= value_next;
            frame_end_reg <= q_word.frame_end;
            list_end_reg  <= q_word.list_end;
        end
    end

    assign out_valid     = valid_reg;
    assign out_kind      = kind_reg;
    assign out_value     = value_reg;
    assign out_frame_end = frame_end_reg;
    assign out_list_end  = list_end_reg;

endmodule

// ----- rtl/core/display_init_sequence_parser.sv -----
// Display init command list parser: top level joining front, queue and back.
// Depends on dinit_pkg, dinit_front, dinit_queue, dinit_back.
//
// Accepts one list byte per clock while s_ready is high and emits at most
// one result per byte: a command (kind 0, DC low), a data byte (kind 1, DC
// high) or a delay in ms (kind 2, 255 reads as 500). frame_end marks where
// chip select rises and list_end flags the last result of a list. The front
// parser updates its position and writes into a two-entry queue; the back
// stage loads the result register from it, so a result goes through a queue
// entry and then the result register before it reaches m_. s_ready drops
// only when the queue is full, which happens only when m_ready is held low.
module display_init_sequence_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_list_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [8:0] m_value,
    output logic       m_frame_end,
    output logic       m_list_end
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_avail;
    dinit_pkg::word_t push_word;
    dinit_pkg::word_t head_word;

    dinit_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_byte  (s_list_byte),
        .in_ready (s_ready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_word   (push_word)
    );

    dinit_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .head_word (head_word)
    );

    dinit_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_avail       (q_avail),
        .q_word        (head_word),
        .q_pop         (q_pop),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_kind      (m_kind),
        .out_value     (m_value),
        .out_frame_end (m_frame_end),
        .out_list_end  (m_list_end)
    );

endmodule
